### src/cfp_pkg.sv
package cfp_pkg;

   localparam int unsigned NAME_LEN = 16;
   localparam int unsigned TYPE_SHIFT = 24;
   localparam logic [23:0] FACTOR_MASK = 24'hFFFFFF;

   typedef enum logic [4:0] {
      PH_SYNC       = 5'd0,
      PH_SIZE       = 5'd1,
      PH_ID         = 5'd2,
      PH_SOC        = 5'd3,
      PH_FRACSEC    = 5'd4,
      PH_TIMEBASE   = 5'd5,
      PH_NSTATIONS  = 5'd6,
      PH_STN_CHAR   = 5'd7,
      PH_STN_ID     = 5'd8,
      PH_FORMAT     = 5'd9,
      PH_PHNMR      = 5'd10,
      PH_ANNMR      = 5'd11,
      PH_DGNMR      = 5'd12,
      PH_PH_CHAR    = 5'd13,
      PH_AN_CHAR    = 5'd14,
      PH_DG_CHAR    = 5'd15,
      PH_PH_UNIT    = 5'd16,
      PH_AN_UNIT    = 5'd17,
      PH_DG_UNIT    = 5'd18,
      PH_FNOM       = 5'd19,
      PH_CFGCNT     = 5'd20,
      PH_DATA_RATE  = 5'd21,
      PH_CHECK      = 5'd22,
      PH_IDLE       = 5'd23
   } phase_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [4:0]  field_kind;
      logic [31:0] field_value;
      logic [7:0]  unit_type;
      logic [15:0] station_index;
      logic [19:0] channel_index;
      logic [3:0]  char_index;
      logic        frame_done;
   } rsp_type;

endpackage

### src/cfp_parser.sv
module cfp_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  cfp_pkg::req_type item,
   output logic             has_rec,
   output cfp_pkg::rsp_type rec
);

   cfp_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic [1:0]  bif_ff, bif_in, cur_bif;
   logic [23:0] shift_ff, shift_in, cur_shift;
   logic [15:0] total_ff, total_in, cur_total;
   logic [15:0] stn_ff, stn_in, cur_stn;
   logic [15:0] nph_ff, nph_in, cur_nph;
   logic [15:0] nan_ff, nan_in, cur_nan;
   logic [15:0] ndg_ff, ndg_in, cur_ndg;
   logic [19:0] chan_ff, chan_in, cur_chan;
   logic [3:0]  name_ff, name_in, cur_name;
   logic [31:0] val;
   logic [19:0] chan_inc;
   logic [15:0] stn_inc;

   function automatic logic [1:0] last_byte(input cfp_pkg::phase_type p);
      logic [1:0] r;
      r = 2'd1;
      if (p inside {cfp_pkg::PH_SOC, cfp_pkg::PH_FRACSEC, cfp_pkg::PH_TIMEBASE,
                    cfp_pkg::PH_PH_UNIT, cfp_pkg::PH_AN_UNIT, cfp_pkg::PH_DG_UNIT}) begin
         r = 2'd3;
      end else if (p inside {cfp_pkg::PH_STN_CHAR, cfp_pkg::PH_PH_CHAR,
                             cfp_pkg::PH_AN_CHAR, cfp_pkg::PH_DG_CHAR}) begin
         r = 2'd0;
      end
      return r;
   endfunction

   function automatic logic [19:0] section_len(input cfp_pkg::phase_type p,
                                               input logic [15:0] ph,
                                               input logic [15:0] an,
                                               input logic [15:0] dg);
      logic [19:0] r;
      case (p)
         cfp_pkg::PH_PH_CHAR, cfp_pkg::PH_PH_UNIT: r = {4'd0, ph};
         cfp_pkg::PH_AN_CHAR, cfp_pkg::PH_AN_UNIT: r = {4'd0, an};
         cfp_pkg::PH_DG_CHAR:                      r = {dg, 4'd0};
         cfp_pkg::PH_DG_UNIT:                      r = {4'd0, dg};
         default:                                  r = 20'd1;
      endcase
      return r;
   endfunction

   // First section at or after the start phase that holds any entries.
   function automatic cfp_pkg::phase_type skip_empty(input logic [4:0]  start,
                                                     input logic [15:0] ph,
                                                     input logic [15:0] an,
                                                     input logic [15:0] dg);
      cfp_pkg::phase_type r;
      logic [5:0] nz;
      nz = {dg != 16'd0, an != 16'd0, ph != 16'd0,
            dg != 16'd0, an != 16'd0, ph != 16'd0};
      r = cfp_pkg::PH_FNOM;
      for (int k = 5; k >= 0; k--) begin
         if (nz[k] && (5'(k) + 5'(cfp_pkg::PH_PH_CHAR) >= start)) begin
            r = cfp_pkg::phase_type'(5'(k) + 5'(cfp_pkg::PH_PH_CHAR));
         end
      end
      return r;
   endfunction

   always_comb begin
      if (item.frame_start) begin
         cur_phase = cfp_pkg::PH_SYNC;
         cur_bif   = '0;
         cur_shift = '0;
         cur_total = '0;
         cur_stn   = '0;
         cur_nph   = '0;
         cur_nan   = '0;
         cur_ndg   = '0;
         cur_chan  = '0;
         cur_name  = '0;
      end else begin
         cur_phase = phase_ff;
         cur_bif   = bif_ff;
         cur_shift = shift_ff;
         cur_total = total_ff;
         cur_stn   = stn_ff;
         cur_nph   = nph_ff;
         cur_nan   = nan_ff;
         cur_ndg   = ndg_ff;
         cur_chan  = chan_ff;
         cur_name  = name_ff;
      end

      phase_in = cur_phase;
      bif_in   = cur_bif;
      shift_in = cur_shift;
      total_in = cur_total;
      stn_in   = cur_stn;
      nph_in   = cur_nph;
      nan_in   = cur_nan;
      ndg_in   = cur_ndg;
      chan_in  = cur_chan;
      name_in  = cur_name;
      has_rec  = 1'b0;
      rec      = '0;
      val      = {cur_shift, item.frame_byte};
      chan_inc = cur_chan + 20'd1;
      stn_inc  = cur_stn + 16'd1;

      if (cur_phase != cfp_pkg::PH_IDLE) begin
         if (cur_bif != last_byte(cur_phase)) begin
            bif_in   = cur_bif + 2'd1;
            shift_in = val[23:0];
         end else begin
            bif_in            = '0;
            shift_in          = '0;
            has_rec           = 1'b1;
            rec.field_kind    = cur_phase;
            rec.field_value   = val;
            case (cur_phase)
               cfp_pkg::PH_NSTATIONS: begin
                  total_in = val[15:0];
                  stn_in   = '0;
                  phase_in = (val[15:0] != 16'd0) ? cfp_pkg::PH_STN_CHAR
                                                  : cfp_pkg::PH_DATA_RATE;
               end
               cfp_pkg::PH_STN_CHAR: begin
                  rec.station_index = cur_stn;
                  rec.char_index    = cur_name;
                  if (cur_name == 4'(cfp_pkg::NAME_LEN - 1)) begin
                     name_in  = '0;
                     phase_in = cfp_pkg::PH_STN_ID;
                  end else begin
                     name_in = cur_name + 4'd1;
                  end
               end
               cfp_pkg::PH_PHNMR: begin
                  rec.station_index = cur_stn;
                  nph_in            = val[15:0];
                  phase_in          = cfp_pkg::PH_ANNMR;
               end
               cfp_pkg::PH_ANNMR: begin
                  rec.station_index = cur_stn;
                  nan_in            = val[15:0];
                  phase_in          = cfp_pkg::PH_DGNMR;
               end
               cfp_pkg::PH_DGNMR: begin
                  rec.station_index = cur_stn;
                  ndg_in            = val[15:0];
                  chan_in           = '0;
                  name_in           = '0;
                  phase_in          = skip_empty(5'(cfp_pkg::PH_PH_CHAR), cur_nph, cur_nan,
                                                 val[15:0]);
               end
               cfp_pkg::PH_PH_CHAR, cfp_pkg::PH_AN_CHAR, cfp_pkg::PH_DG_CHAR: begin
                  rec.station_index = cur_stn;
                  rec.channel_index = cur_chan;
                  rec.char_index    = cur_name;
                  if (cur_name == 4'(cfp_pkg::NAME_LEN - 1)) begin
                     name_in = '0;
                     if (chan_inc >= section_len(cur_phase, cur_nph, cur_nan, cur_ndg)) begin
                        chan_in  = '0;
                        phase_in = skip_empty(5'(cur_phase) + 5'd1, cur_nph, cur_nan, cur_ndg);
                     end else begin
                        chan_in = chan_inc;
                     end
                  end else begin
                     name_in = cur_name + 4'd1;
                  end
               end
               cfp_pkg::PH_PH_UNIT, cfp_pkg::PH_AN_UNIT, cfp_pkg::PH_DG_UNIT: begin
                  rec.station_index = cur_stn;
                  rec.channel_index = cur_chan;
                  if (cur_phase != cfp_pkg::PH_DG_UNIT) begin
                     rec.field_value = {8'd0, val[23:0] & cfp_pkg::FACTOR_MASK};
                     rec.unit_type   = val[cfp_pkg::TYPE_SHIFT +: 8];
                  end
                  if (chan_inc >= section_len(cur_phase, cur_nph, cur_nan, cur_ndg)) begin
                     chan_in  = '0;
                     phase_in = skip_empty(5'(cur_phase) + 5'd1, cur_nph, cur_nan, cur_ndg);
                  end else begin
                     chan_in = chan_inc;
                  end
               end
               cfp_pkg::PH_STN_ID, cfp_pkg::PH_FORMAT, cfp_pkg::PH_FNOM: begin
                  rec.station_index = cur_stn;
                  phase_in          = cfp_pkg::phase_type'(5'(cur_phase) + 5'd1);
               end
               cfp_pkg::PH_CFGCNT: begin
                  rec.station_index = cur_stn;
                  stn_in            = stn_inc;
                  phase_in          = (stn_inc == cur_total) ? cfp_pkg::PH_DATA_RATE
                                                             : cfp_pkg::PH_STN_CHAR;
               end
               cfp_pkg::PH_CHECK: begin
                  rec.frame_done = 1'b1;
                  phase_in       = cfp_pkg::PH_IDLE;
               end
               default: begin
                  phase_in = cfp_pkg::phase_type'(5'(cur_phase) + 5'd1);
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cfp_pkg::PH_SYNC;
         bif_ff   <= '0;
         shift_ff <= '0;
         total_ff <= '0;
         stn_ff   <= '0;
         nph_ff   <= '0;
         nan_ff   <= '0;
         ndg_ff   <= '0;
         chan_ff  <= '0;
         name_ff  <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         bif_ff   <= bif_in;
         shift_ff <= shift_in;
         total_ff <= total_in;
         stn_ff   <= stn_in;
         nph_ff   <= nph_in;
         nan_ff   <= nan_in;
         ndg_ff   <= ndg_in;
         chan_ff  <= chan_in;
         name_ff  <= name_in;
      end
   end

endmodule

### src/phasor_config_frame_parser_top.sv
// Parses a synchrophasor configuration frame (CFG-2 layout) one byte per request, most
// significant byte of each field first, and emits one record per completed field or name
// character, with the station, channel and character position it belongs to. A request
// with frame_start set restarts the parser on that byte; bytes after the check word are
// dropped until the next frame_start. One byte is taken every clock cycle while req_stall
// is low: each request passes through an input register, the field assembly and counter
// logic, and a result register, so the record of a byte is written to the result register
// as that byte leaves the input register. Stall on the result side backs up to req_stall
// only once both the input and the result registers are full.
module phasor_config_frame_parser_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cfp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cfp_pkg::rsp_type rsp_data
);

   logic             in_valid_ff, in_valid_in;
   cfp_pkg::req_type in_ff;
   logic             out_valid_ff, out_valid_in;
   cfp_pkg::rsp_type out_ff;
   logic             out_free, fire, req_take, has_rec;
   cfp_pkg::rsp_type rec;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !fire);
   assign out_valid_in = out_free ? (fire && has_rec) : out_valid_ff;

   cfp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .item    (in_ff),
      .has_rec (has_rec),
      .rec     (rec)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_data;
      end
      if (fire && has_rec) begin
         out_ff <= rec;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_done_on_check: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_done) |-> (rsp_data.field_kind == 5'(cfp_pkg::PH_CHECK)))
      else $error("frame_done set on a record that is not the check word");

   a_unit_type_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.unit_type != 8'd0)) |->
         ((rsp_data.field_kind == 5'(cfp_pkg::PH_PH_UNIT)) ||
          (rsp_data.field_kind == 5'(cfp_pkg::PH_AN_UNIT))))
      else $error("unit type reported outside a phasor or analog unit record");

   a_char_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.char_index != 4'd0)) |->
         ((rsp_data.field_kind == 5'(cfp_pkg::PH_STN_CHAR)) ||
          (rsp_data.field_kind == 5'(cfp_pkg::PH_PH_CHAR)) ||
          (rsp_data.field_kind == 5'(cfp_pkg::PH_AN_CHAR)) ||
          (rsp_data.field_kind == 5'(cfp_pkg::PH_DG_CHAR))))
      else $error("character position reported outside a name record");

   a_stall_needs_both_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid && rsp_stall))
      else $error("request stalled while a register stage was free");

endmodule

### test/phasor_config_frame_parser_top_test.sv
module phasor_config_frame_parser_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cfp_pkg::*;

   localparam int WHOLE_FRAME = 32'h7FFF_FFFF;
   localparam int TARGET_ITEMS = 1200;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_AT = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam int STALL_LIMIT = 3000;

   class frame_record_checker;
      phase_type      phase;
      int             byte_count;
      logic [31:0]    shift_reg;
      logic [15:0]    station_total;
      logic [15:0]    station_num;
      logic [15:0]    phasor_count;
      logic [15:0]    analog_count;
      logic [15:0]    digital_count;
      logic [19:0]    channel_num;
      logic [3:0]     char_num;
      rsp_type        pending_records[$];
      int             mismatches;

      function new();
         clear();
         mismatches = 0;
      endfunction

      function void clear();
         phase = PH_SYNC;
         byte_count = 0;
         shift_reg = '0;
         station_total = '0;
         station_num = '0;
         phasor_count = '0;
         analog_count = '0;
         digital_count = '0;
         channel_num = '0;
         char_num = '0;
      endfunction

      function int unsigned field_width(phase_type p);
         if ((p >= PH_SOC && p <= PH_TIMEBASE) || (p >= PH_PH_UNIT && p <= PH_DG_UNIT))
            return 4;
         if (p == PH_STN_CHAR || (p >= PH_PH_CHAR && p <= PH_DG_CHAR))
            return 1;
         return 2;
      endfunction

      function int unsigned section_size(phase_type p);
         case (p)
            PH_PH_CHAR, PH_PH_UNIT: return phasor_count;
            PH_AN_CHAR, PH_AN_UNIT: return analog_count;
            PH_DG_CHAR: return NAME_LEN * digital_count;
            PH_DG_UNIT: return digital_count;
            default: return 1;
         endcase
      endfunction

      function phase_type skip_empty_sections(phase_type p);
         while (p >= PH_PH_CHAR && p <= PH_DG_UNIT && section_size(p) == 0)
            p = phase_type'(p + 5'd1);
         return p;
      endfunction

      function void advance_channel();
         channel_num = channel_num + 20'd1;
         if (channel_num >= section_size(phase)) begin
            channel_num = '0;
            phase = skip_empty_sections(phase_type'(phase + 5'd1));
         end
      endfunction

      function void take_byte(req_type r);
         rsp_type     rec;
         logic [31:0] val;
         if (r.frame_start)
            clear();
         if (phase == PH_IDLE)
            return;
         shift_reg = {shift_reg[23:0], r.frame_byte};
         if (byte_count + 1 < field_width(phase)) begin
            byte_count++;
            return;
         end
         byte_count = 0;
         val = shift_reg;
         shift_reg = '0;
         rec = '0;
         rec.field_kind = phase;
         rec.field_value = val;
         case (phase)
            PH_SYNC, PH_SIZE, PH_ID, PH_SOC, PH_FRACSEC, PH_TIMEBASE: begin
               phase = phase_type'(phase + 5'd1);
            end
            PH_NSTATIONS: begin
               station_total = val[15:0];
               station_num = '0;
               phase = (station_total != 0) ? PH_STN_CHAR : PH_DATA_RATE;
            end
            PH_STN_CHAR: begin
               rec.station_index = station_num;
               rec.char_index = char_num;
               if (char_num == 4'(NAME_LEN - 1)) begin
                  char_num = '0;
                  phase = PH_STN_ID;
               end else begin
                  char_num++;
               end
            end
            PH_STN_ID, PH_FORMAT: begin
               rec.station_index = station_num;
               phase = phase_type'(phase + 5'd1);
            end
            PH_PHNMR: begin
               rec.station_index = station_num;
               phasor_count = val[15:0];
               phase = PH_ANNMR;
            end
            PH_ANNMR: begin
               rec.station_index = station_num;
               analog_count = val[15:0];
               phase = PH_DGNMR;
            end
            PH_DGNMR: begin
               rec.station_index = station_num;
               digital_count = val[15:0];
               channel_num = '0;
               char_num = '0;
               phase = skip_empty_sections(PH_PH_CHAR);
            end
            PH_PH_CHAR, PH_AN_CHAR, PH_DG_CHAR: begin
               rec.station_index = station_num;
               rec.channel_index = channel_num;
               rec.char_index = char_num;
               if (char_num == 4'(NAME_LEN - 1)) begin
                  char_num = '0;
                  advance_channel();
               end else begin
                  char_num++;
               end
            end
            PH_PH_UNIT, PH_AN_UNIT: begin
               rec.station_index = station_num;
               rec.channel_index = channel_num;
               rec.field_value = 32'(val[23:0] & FACTOR_MASK);
               rec.unit_type = 8'(val >> TYPE_SHIFT);
               advance_channel();
            end
            PH_DG_UNIT: begin
               rec.station_index = station_num;
               rec.channel_index = channel_num;
               advance_channel();
            end
            PH_FNOM: begin
               rec.station_index = station_num;
               phase = PH_CFGCNT;
            end
            PH_CFGCNT: begin
               rec.station_index = station_num;
               station_num = station_num + 16'd1;
               phase = (station_num == station_total) ? PH_DATA_RATE : PH_STN_CHAR;
            end
            PH_DATA_RATE: begin
               phase = PH_CHECK;
            end
            default: begin
               rec.frame_done = 1'b1;
               phase = PH_IDLE;
            end
         endcase
         pending_records = {pending_records, rec};
      endfunction

      function string describe(rsp_type r);
         return $sformatf("kind %0d value %h type %h station %0d channel %0d char %0d done %b",
                          r.field_kind, r.field_value, r.unit_type, r.station_index,
                          r.channel_index, r.char_index, r.frame_done);
      endfunction

      function void check_record(rsp_type actual);
         rsp_type wanted;
         if (pending_records.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected record: expected none, actual %s", describe(actual));
            return;
         end
         wanted = pending_records.pop_front();
         if (actual.field_kind !== wanted.field_kind || actual.field_value !== wanted.field_value
             || actual.unit_type !== wanted.unit_type
             || actual.station_index !== wanted.station_index
             || actual.channel_index !== wanted.channel_index
             || actual.char_index !== wanted.char_index
             || actual.frame_done !== wanted.frame_done) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("record mismatch");
               $display("   expected %s", describe(wanted));
               $display("   actual   %s", describe(actual));
            end
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   frame_record_checker frame_checker;
   req_type             request_queue[$];
   int                  frame_len;
   int                  frame_cut;
   int                  counted_items;
   bit                  requests_done;
   int                  quiet_cycles;

   phasor_config_frame_parser_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("phasor_config_frame_parser_top_test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int next_gap(inout int stretch_left, inout bit no_gaps);
      if (stretch_left == 0) begin
         stretch_left = $urandom_range(8, 60);
         no_gaps = ($urandom_range(0, 2) == 0);
      end
      stretch_left--;
      return no_gaps ? 0 : $urandom_range(0, 14);
   endfunction

   task automatic add_field(logic [31:0] value, int nbytes);
      req_type r;
      for (int i = nbytes - 1; i >= 0; i--) begin
         if (frame_len < frame_cut) begin
            r.frame_byte = value[8*i +: 8];
            r.frame_start = (frame_len == 0);
            request_queue = {request_queue, r};
            counted_items++;
            frame_len++;
         end
      end
   endtask

   task automatic add_trailing_bytes(int count);
      req_type r;
      repeat (count) begin
         r.frame_byte = 8'($urandom);
         r.frame_start = 1'b0;
         request_queue = {request_queue, r};
      end
   endtask

   task automatic add_frame(logic [15:0] stations, bit huge_counts, int cut);
      logic [15:0] phasors;
      logic [15:0] analogs;
      logic [15:0] digitals;
      frame_len = 0;
      frame_cut = cut;
      add_field($urandom, 2);
      add_field($urandom, 2);
      add_field($urandom, 2);
      add_field($urandom, 4);
      add_field($urandom, 4);
      add_field($urandom, 4);
      add_field(32'(stations), 2);
      for (int s = 0; s < stations && frame_len < frame_cut; s++) begin
         for (int c = 0; c < NAME_LEN; c++)
            add_field($urandom, 1);
         add_field($urandom, 2);
         add_field($urandom, 2);
         phasors = huge_counts ? 16'($urandom) : 16'($urandom_range(0, 3));
         analogs = huge_counts ? 16'($urandom) : 16'($urandom_range(0, 3));
         digitals = huge_counts ? 16'($urandom) : 16'($urandom_range(0, 7) == 0);
         add_field(32'(phasors), 2);
         add_field(32'(analogs), 2);
         add_field(32'(digitals), 2);
         for (int c = 0; c < NAME_LEN * (phasors + analogs + NAME_LEN * digitals)
              && frame_len < frame_cut; c++)
            add_field($urandom, 1);
         for (int c = 0; c < phasors + analogs + digitals && frame_len < frame_cut; c++)
            add_field($urandom, 4);
         add_field($urandom, 2);
         add_field($urandom, 2);
      end
      add_field($urandom, 2);
      add_field($urandom, 2);
   endtask

   task automatic build_requests();
      // A frame with no stations and extreme header values, then bytes that must be dropped.
      frame_len = 0;
      frame_cut = WHOLE_FRAME;
      add_field(32'h0000_FFFF, 2);
      add_field(32'h0000_0000, 2);
      add_field(32'h0000_FFFF, 2);
      add_field(32'hFFFF_FFFF, 4);
      add_field(32'h0000_0000, 4);
      add_field(32'hFFFF_FFFF, 4);
      add_field(32'h0000_0000, 2);
      add_field(32'h0000_FFFF, 2);
      add_field(32'h0000_0000, 2);
      add_trailing_bytes(3);
      while (counted_items < TARGET_ITEMS) begin
         case ($urandom_range(0, 9))
            0: add_frame($urandom_range(0, 1) ? 16'hFFFF : 16'($urandom), 1'b1,
                         $urandom_range(1, 120));
            1: add_frame(16'($urandom_range(0, 3)), 1'b0, $urandom_range(1, 150));
            default: begin
               add_frame(16'($urandom_range(0, 3)), 1'b0, WHOLE_FRAME);
               if ($urandom_range(0, 3) == 0)
                  add_trailing_bytes($urandom_range(1, 6));
            end
         endcase
      end
   endtask

   task automatic drive_requests();
      int gap;
      int stretch_left = 0;
      bit no_gaps = 1'b0;
      foreach (request_queue[i]) begin
         gap = next_gap(stretch_left, no_gaps);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid = 1'b1;
         req_data = request_queue[i];
         do @(posedge clock); while (req_stall);
         frame_checker.take_byte(request_queue[i]);
         @(negedge clock);
      end
      req_valid = 1'b0;
      requests_done = 1'b1;
   endtask

   task automatic collect_records();
      int gap;
      int stretch_left = 0;
      int received = 0;
      bit no_gaps = 1'b0;
      forever begin
         gap = next_gap(stretch_left, no_gaps);
         // One long hold-off lets the pipeline fill and push back on the request side.
         if (received == HOLD_OFF_AT)
            gap = HOLD_OFF_CYCLES;
         if (gap > 0) begin
            rsp_stall = 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         frame_checker.check_record(rsp_data);
         received++;
         @(negedge clock);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      requests_done = 1'b0;
      counted_items = 0;
      frame_checker = new();
      build_requests();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      fork
         drive_requests();
         collect_records();
      join_none
      wait (requests_done);
      while (frame_checker.pending_records.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (frame_checker.mismatches == 0 && frame_checker.pending_records.size() == 0) begin
         $display("phasor_config_frame_parser_top_test passed");
      end else begin
         $display("phasor_config_frame_parser_top_test failed");
      end
      $finish;
   end

endmodule

### sim.f
src/cfp_pkg.sv
src/cfp_parser.sv
src/phasor_config_frame_parser_top.sv
test/phasor_config_frame_parser_top_test.sv
